/* rtl/digital_net_point_digits_assert.svh */
// Assertion macros shared by the digital net point digit RTL
`ifndef DIGITAL_NET_POINT_DIGITS_ASSERT_SVH
`define DIGITAL_NET_POINT_DIGITS_ASSERT_SVH

// same-cycle implication
`define DNPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnpd: same-cycle check failed");

// next-cycle implication
`define DNPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnpd: next-cycle check failed");

`endif

/* rtl/dnpd_pkg.sv */
// Shared constants, field layout and chain link type for the point digit generator
`default_nettype none
package dnpd_pkg;

   localparam int MATRIX_SETS_DEF = 16;
   localparam int MAX_COLS_DEF    = 32;
   localparam int MAX_ROWS_DEF    = 32;

   localparam int DIGIT_W   = 8;
   localparam int IDX_W     = 32;
   localparam int SET_IDX_W = 4;
   localparam int POS_W     = 5;
   localparam int PROD_W    = 2 * DIGIT_W;
   localparam int TAG_W     = 6;
   localparam int DIV_STEPS = 4;

   // request tdata layout, lowest bit first
   localparam int SET_LSB    = 0;
   localparam int COL_LSB    = SET_LSB + SET_IDX_W;
   localparam int ROW_LSB    = COL_LSB + POS_W;
   localparam int ENTRY_LSB  = ROW_LSB + POS_W;
   localparam int IDX_LSB    = ENTRY_LSB + DIGIT_W;
   localparam int BASE_LSB   = IDX_LSB + IDX_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 1'b1;

   localparam logic ACT_LOAD     = 1'b0;
   localparam logic ACT_GENERATE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  row;
      logic [PROD_W-1:0] value;
   } chain_type;

endpackage
`default_nettype wire

/* rtl/dnpd_cell.sv */
// One reduction cell: conditionally subtracts base shifted by SHIFT, then registers
`default_nettype none
module dnpd_cell #(
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dnpd_pkg::DIGIT_W-1:0]  base,
   input  dnpd_pkg::chain_type           prev_link,
   output dnpd_pkg::chain_type           next_link
);
   import dnpd_pkg::*;

   localparam int CMP_W = PROD_W + DIGIT_W;

   logic [CMP_W-1:0] limit;
   logic [CMP_W-1:0] wide;
   chain_type        stage_ff;
   chain_type        stage_in;

   always_comb begin
      limit    = CMP_W'(base) << SHIFT;
      wide     = CMP_W'(prev_link.value);
      stage_in = prev_link;
      if (wide >= limit) begin
         stage_in.value = PROD_W'(wide - limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_link = stage_ff;

endmodule
`default_nettype wire

/* rtl/dnpd_divider.sv */
// Iterative restoring divider: index by base, several quotient bits per cycle
`default_nettype none
module dnpd_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dnpd_pkg::IDX_W-1:0]   dividend,
   input  logic [dnpd_pkg::DIGIT_W-1:0] divisor,
   output logic                         done,
   output logic [dnpd_pkg::IDX_W-1:0]   quotient,
   output logic [dnpd_pkg::DIGIT_W-1:0] remainder
);
   import dnpd_pkg::*;

   localparam int ITER   = IDX_W / DIV_STEPS;
   localparam int ITER_W = $clog2(ITER);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ITER_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [DIGIT_W:0]   part;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      part    = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            part   = {rem_in, quo_in[IDX_W-1]};
            quo_in = {quo_in[IDX_W-2:0], 1'b0};
            if (part >= {1'b0, divisor}) begin
               part      = part - {1'b0, divisor};
               quo_in[0] = 1'b1;
            end
            rem_in = part[DIGIT_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* rtl/digital_net_point_digits.sv */
// Top level: matrix store, digit extraction, reduction cell chain and result sequencing
// Load request: written to the matrix memory, no result.
// Generate request: per base-b digit a division in the divider (4 bits/cycle), plus nrows
// column reads for a nonzero digit, then a drain of the 16-cell chain, then nrows results or one overflow.
// One request is in work at a time; the next is taken once the last result is registered.
// Reset is synchronous: control clears, both counts go to 32, the matrix memory keeps its contents.
`default_nettype none
`include "digital_net_point_digits_assert.svh"
module digital_net_point_digits #(
   parameter int MATRIX_SETS = dnpd_pkg::MATRIX_SETS_DEF,
   parameter int MAX_COLS    = dnpd_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = dnpd_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // set_index[3:0], column[8:4], row[13:9], entry_value[21:14],
   // point_index[53:22], base[61:54], zero pad[63:62]
   input  logic [dnpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // digit[7:0], row_out[12:8], zero pad[15:13]
   output logic [dnpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // overflow[0]
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [dnpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dnpd_pkg::CSR_W-1:0]        csr_wdata
);
   import dnpd_pkg::*;

   localparam int DEPTH      = MATRIX_SETS * MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SET_W      = (MATRIX_SETS > 1) ? $clog2(MATRIX_SETS) : 1;
   localparam int SET_STRIDE = MAX_COLS * MAX_ROWS;
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROWC_W     = $clog2(MAX_ROWS + 1);
   localparam int COLC_W     = $clog2(MAX_COLS + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_GO   = 3'd1;
   localparam logic [2:0] ST_DIV_WAIT = 3'd2;
   localparam logic [2:0] ST_ISSUE    = 3'd3;
   localparam logic [2:0] ST_DRAIN    = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;
   localparam logic [2:0] ST_OVF      = 3'd6;

   // request fields
   logic [SET_IDX_W-1:0] req_set_index;
   logic [POS_W-1:0]     req_column;
   logic [POS_W-1:0]     req_row;
   logic [DIGIT_W-1:0]   req_entry_value;
   logic [IDX_W-1:0]     req_point_index;
   logic [DIGIT_W-1:0]   req_base;
   logic [SET_W-1:0]     req_set_mod;
   logic                 load_ok;

   assign req_set_index   = req_tdata[SET_LSB +: SET_IDX_W];
   assign req_column      = req_tdata[COL_LSB +: POS_W];
   assign req_row         = req_tdata[ROW_LSB +: POS_W];
   assign req_entry_value = req_tdata[ENTRY_LSB +: DIGIT_W];
   assign req_point_index = req_tdata[IDX_LSB +: IDX_W];
   assign req_base        = req_tdata[BASE_LSB +: DIGIT_W];

   always_comb begin
      req_set_mod = '0;
      for (int i = 0; i < (1 << SET_IDX_W); i++) begin
         if (req_set_index == SET_IDX_W'(i)) begin
            req_set_mod = SET_W'(i % MATRIX_SETS);
         end
      end
   end

   assign load_ok = (int'(req_column) < MAX_COLS) && (int'(req_row) < MAX_ROWS);

   // control and generate state
   logic [2:0]         state_ff, state_in;
   logic [CSR_W-1:0]   rows_used_ff, rows_used_in;
   logic [CSR_W-1:0]   cols_used_ff, cols_used_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DIGIT_W-1:0] base_ff, base_in;
   logic [DIGIT_W-1:0] dig_ff, dig_in;
   logic [COLC_W-1:0]  k_ff, k_in;
   logic [ROW_W-1:0]   t_ff, t_in;
   logic               ovf_pend_ff, ovf_pend_in;
   logic [ROWC_W-1:0]  nrows;
   logic [COLC_W-1:0]  ncols;
   logic               t_last;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic [POS_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_load;

   // memory and pipeline
   logic [DIGIT_W-1:0] matrix_mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic               s1_valid_ff;
   logic [TAG_W-1:0]   s1_row_ff;
   logic [DIGIT_W-1:0] s1_dig_ff;
   chain_type          head_ff;
   chain_type          link [PROD_W+1];
   chain_type          tail;
   logic               pipe_busy;

   // accumulators
   logic [DIGIT_W-1:0] acc_ff [MAX_ROWS];
   logic [ROW_W-1:0]   acc_raddr;
   logic [DIGIT_W-1:0] acc_rdata;
   logic [DIGIT_W:0]   acc_sum;
   logic               acc_clear;

   // divider
   logic               div_start;
   logic               div_done;
   logic [IDX_W-1:0]   div_quo;
   logic [DIGIT_W-1:0] div_rem;

   // saturate the counts into their legal ranges
   always_comb begin
      if (rows_used_ff == '0) begin
         nrows = ROWC_W'(1);
      end else if (int'(rows_used_ff) > MAX_ROWS) begin
         nrows = ROWC_W'(MAX_ROWS);
      end else begin
         nrows = ROWC_W'(rows_used_ff);
      end
      if (cols_used_ff == '0) begin
         ncols = COLC_W'(1);
      end else if (int'(cols_used_ff) > MAX_COLS) begin
         ncols = COLC_W'(MAX_COLS);
      end else begin
         ncols = COLC_W'(cols_used_ff);
      end
   end

   assign t_last   = (ROWC_W'(t_ff) + 1'b1) == nrows;
   assign rsp_load = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign wr_addr = ADDR_W'(req_set_mod) * ADDR_W'(SET_STRIDE)
                  + ADDR_W'(req_column) * ADDR_W'(MAX_ROWS) + ADDR_W'(req_row);
   assign rd_addr = ADDR_W'(set_ff) * ADDR_W'(SET_STRIDE)
                  + ADDR_W'(k_ff) * ADDR_W'(MAX_ROWS) + ADDR_W'(t_ff);

   always_comb begin
      state_in     = state_ff;
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      set_in       = set_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      dig_in       = dig_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      ovf_pend_in  = ovf_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_digit_in = rsp_digit_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      acc_clear    = 1'b0;
      div_start    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_USED: rows_used_in = csr_wdata;
            CSR_COLS_USED: cols_used_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ACT_LOAD) begin
                  mem_we = load_ok;
               end else begin
                  set_in      = req_set_mod;
                  base_in     = req_base;
                  idx_in      = req_point_index;
                  k_in        = '0;
                  t_in        = '0;
                  ovf_pend_in = 1'b0;
                  acc_clear   = 1'b1;
                  if (req_base < DIGIT_W'(2)) begin
                     state_in = ST_OVF;
                  end else if (req_point_index == '0) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_DIV_GO;
                  end
               end
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               idx_in = div_quo;
               dig_in = div_rem;
               if (k_ff >= ncols) begin
                  ovf_pend_in = 1'b1;
                  state_in    = ST_DRAIN;
               end else if (div_rem == '0) begin
                  k_in     = k_ff + 1'b1;
                  state_in = (div_quo == '0) ? ST_DRAIN : ST_DIV_GO;
               end else begin
                  t_in     = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            t_in = t_ff + 1'b1;
            if (t_last) begin
               t_in     = '0;
               k_in     = k_ff + 1'b1;
               state_in = (idx_ff == '0) ? ST_DRAIN : ST_DIV_GO;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               t_in     = '0;
               state_in = ovf_pend_ff ? ST_OVF : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = acc_rdata;
               rsp_row_in   = POS_W'(t_ff);
               rsp_last_in  = t_last;
               rsp_ovf_in   = 1'b0;
               t_in         = t_ff + 1'b1;
               if (t_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OVF: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = '0;
               rsp_row_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = 1'b1;
               ovf_pend_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_used_ff <= CSR_W'(32);
         cols_used_ff <= CSR_W'(32);
         ovf_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         t_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         ovf_pend_ff  <= ovf_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         t_ff         <= t_in;
      end
      set_ff       <= set_in;
      idx_ff       <= idx_in;
      base_ff      <= base_in;
      dig_ff       <= dig_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // matrix memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_mem[wr_addr] <= req_entry_value;
      end
      rd_data_ff <= matrix_mem[rd_addr];
   end

   // tag the read, then form digit times matrix entry
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         head_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff   <= (state_ff == ST_ISSUE);
         head_ff.valid <= s1_valid_ff;
      end
      s1_row_ff     <= TAG_W'(t_ff);
      s1_dig_ff     <= dig_ff;
      head_ff.row   <= s1_row_ff;
      head_ff.value <= PROD_W'(s1_dig_ff) * PROD_W'(rd_data_ff);
   end

   assign link[0] = head_ff;

   // each cell strips one power-of-two multiple of base, highest first
   for (genvar g = 0; g < PROD_W; g++) begin : g_cell
      dnpd_cell #(
         .SHIFT (PROD_W - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .base      (base_ff),
         .prev_link (link[g]),
         .next_link (link[g+1])
      );
   end

   assign tail = link[PROD_W];

   always_comb begin
      pipe_busy = s1_valid_ff;
      for (int i = 0; i <= PROD_W; i++) begin
         pipe_busy = pipe_busy | link[i].valid;
      end
   end

   // accumulators: one read address, shared by the update and the result phase
   assign acc_raddr = (state_ff == ST_EMIT) ? t_ff : tail.row[ROW_W-1:0];
   assign acc_rdata = acc_ff[acc_raddr];

   always_comb begin
      acc_sum = {1'b0, acc_rdata} + {1'b0, tail.value[DIGIT_W-1:0]};
      if (acc_sum >= {1'b0, base_ff}) begin
         acc_sum = acc_sum - {1'b0, base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (acc_clear) begin
         for (int i = 0; i < MAX_ROWS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (tail.valid) begin
         acc_ff[acc_raddr] <= acc_sum[DIGIT_W-1:0];
      end
   end

   dnpd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (idx_ff),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - DIGIT_W - POS_W)'(0), rsp_row_ff, rsp_digit_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   logic tail_row_ok;
   logic rsp_ovf_shown;
   logic issue_in_range;
   assign tail_row_ok    = (int'(tail.row) < int'(nrows));
   assign rsp_ovf_shown  = rsp_valid_ff && rsp_ovf_ff;
   assign issue_in_range = (k_ff < ncols);

   `DNPD_ASSERT_IMP(a_idle_drained, clock, reset, state_ff == ST_IDLE, !pipe_busy)
   `DNPD_ASSERT_IMP(a_tail_row, clock, reset, tail.valid, tail_row_ok)
   `DNPD_ASSERT_IMP(a_ovf_is_last, clock, reset, rsp_ovf_shown, rsp_last_ff)
   `DNPD_ASSERT_IMP(a_issue_col, clock, reset, state_ff == ST_ISSUE, issue_in_range)
   `DNPD_ASSERT_IMP(a_div_owner, clock, reset, div_done, state_ff == ST_DIV_WAIT)
   `DNPD_ASSERT_NEXT(a_stay_drained, clock, reset, !pipe_busy && state_ff != ST_ISSUE, !pipe_busy)

endmodule
`default_nettype wire

/* test/tb_digital_net_point_digits.sv */
// Self-checking testbench for the digital net point digit generator: stream stimulus and scoreboard
`timescale 1ns / 100ps

module tb_digital_net_point_digits;
   import dnpd_pkg::*;

   typedef struct {
      bit [7:0] digit;
      bit [4:0] row;
      bit       last;
      bit       ovf;
   } point_digit_type;

   class digit_scoreboard_type;
      bit [7:0]        matrix [0:16383];
      bit [5:0]        rows_reg;
      bit [5:0]        cols_reg;
      point_digit_type pending_digits [$];
      int              mismatches;
      int              n_loads;
      int              n_points;
      int              n_digits;
      int              n_overflows;

      function new();
         rows_reg = 6'd32;
         cols_reg = 6'd32;
         foreach (matrix[i]) matrix[i] = 8'd0;
      endfunction

      function int rows_in_use();
         if (rows_reg < 1) return 1;
         if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
         return rows_reg;
      endfunction

      function int cols_in_use();
         if (cols_reg < 1) return 1;
         if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
         return cols_reg;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, bit [5:0] value);
         if (idx == CSR_ROWS_USED) rows_reg = value;
         else if (idx == CSR_COLS_USED) cols_reg = value;
      endfunction

      function void push_digit(bit [7:0] d, bit [4:0] r, bit l, bit o);
         point_digit_type e;
         e.digit = d;
         e.row   = r;
         e.last  = l;
         e.ovf   = o;
         pending_digits.push_back(e);
      endfunction

      // note an accepted request and work out the digits it produces
      function void note_request(logic act, bit [3:0] set, bit [4:0] col, bit [4:0] row,
                                 bit [7:0] val, bit [31:0] idx, bit [7:0] b);
         bit [7:0]  acc [0:31];
         bit [31:0] x;
         bit [31:0] dig;
         int        k;
         int        nr;
         int        nc;
         if (act == ACT_LOAD) begin
            matrix[{set, col, row}] = val;
            n_loads++;
            return;
         end
         n_points++;
         nr = rows_in_use();
         nc = cols_in_use();
         if (b < 2) begin
            push_digit(8'd0, 5'd0, 1'b1, 1'b1);
            return;
         end
         foreach (acc[t]) acc[t] = 8'd0;
         x = idx;
         k = 0;
         while (x > 0) begin
            dig = x % b;
            x = x / b;
            if (k >= nc) begin
               push_digit(8'd0, 5'd0, 1'b1, 1'b1);
               return;
            end
            if (dig > 0) begin
               for (int t = 0; t < nr; t++)
                  acc[t] = 8'((acc[t] + dig * matrix[{set, k[4:0], t[4:0]}]) % b);
            end
            k++;
         end
         for (int t = 0; t < nr; t++)
            push_digit(acc[t], t[4:0], (t + 1 == nr), 1'b0);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] data, logic lst, logic ovf);
         point_digit_type e;
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%h last=%b ovf=%b",
                                      data, lst, ovf));
            return;
         end
         e = pending_digits.pop_front();
         n_digits++;
         if (ovf === 1'b1) n_overflows++;
         if (data[7:0] !== e.digit)
            report_mismatch($sformatf("digit %h, want %h (row %0d)", data[7:0], e.digit, e.row));
         if (data[12:8] !== e.row)
            report_mismatch($sformatf("row_out %0d, want %0d", data[12:8], e.row));
         if (lst !== e.last)
            report_mismatch($sformatf("last %b, want %b (row %0d)", lst, e.last, e.row));
         if (ovf !== e.ovf)
            report_mismatch($sformatf("overflow %b, want %b", ovf, e.ovf));
      endtask
   endclass

   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 14;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   digit_scoreboard_type sb = new();
   bit  loaded [0:16383];
   int  snd_idle_pct;
   int  rcv_idle_pct;
   logic hold_start;
   int  hold_left;
   int  quiet_cycles;

   digital_net_point_digits dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result side: check, then pick next ready, honoring a long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task send_request(logic act, bit [3:0] set, bit [4:0] col, bit [4:0] row,
                     bit [7:0] val, bit [31:0] idx, bit [7:0] b);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, b, idx, val, row, col, set};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(act, set, col, row, val, idx, b);
   endtask

   task send_load(bit [3:0] set, bit [4:0] col, bit [4:0] row, bit [7:0] val);
      loaded[{set, col, row}] = 1'b1;
      send_request(ACT_LOAD, set, col, row, val, $urandom, 8'($urandom));
   endtask

   // load any matrix digit the point would read, then send the point
   task send_point(bit [3:0] set, bit [31:0] idx, bit [7:0] b);
      bit [31:0] x;
      int        k;
      int        nr;
      int        nc;
      nr = sb.rows_in_use();
      nc = sb.cols_in_use();
      x = idx;
      k = 0;
      if (b >= 2) begin
         while (x > 0 && k < nc) begin
            for (int t = 0; t < nr; t++)
               if (!loaded[{set, k[4:0], t[4:0]}])
                  send_load(set, k[4:0], t[4:0], 8'($urandom));
            x = x / b;
            k++;
         end
      end
      send_request(ACT_GENERATE, set, 5'($urandom), 5'($urandom), 8'($urandom), idx, b);
   endtask

   // hold requests until every expected digit is back, then let the block settle
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_counts(bit [5:0] rows, bit [5:0] cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS_USED;
      csr_wdata <= rows;
      @(posedge clock);
      sb.write_reg(CSR_ROWS_USED, rows);
      csr_index <= CSR_COLS_USED;
      csr_wdata <= cols;
      @(posedge clock);
      sb.write_reg(CSR_COLS_USED, cols);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // points stay on one matrix set per phase so the preloads stay few
   task random_item(bit [3:0] pset);
      bit [31:0] idx;
      bit [7:0]  b;
      int        sel;
      if ($urandom_range(0, 99) < 25) begin
         send_load(4'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
         return;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) idx = 32'd0;
      else if (sel == 1) idx = 32'hFFFF_FFFF;
      else idx = $urandom >> $urandom_range(0, 31);
      sel = $urandom_range(0, 19);
      if (sel == 0) b = 8'($urandom_range(0, 1));
      else if (sel < 4) b = 8'd2;
      else if (sel < 6) b = 8'd255;
      else b = 8'($urandom_range(2, 255));
      send_point(pset, idx, b);
   endtask

   initial begin
      bit [5:0] rows_set [0:4];
      bit [5:0] cols_set [0:4];
      rows_set = '{6'd0, 6'd5, 6'd63, 6'd1, 6'd0};
      cols_set = '{6'd63, 6'd3, 6'd0, 6'd32, 6'd0};
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= 1'b0;
      rsp_tready   <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_ROWS_USED;
      csr_wdata    <= '0;
      hold_start   <= 1'b0;
      hold_left    = 0;
      quiet_cycles <= 0;
      snd_idle_pct = 27;
      rcv_idle_pct = 64;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset counts: zero index and short bases read nothing
      send_point(4'd0, 32'd0, 8'd2);
      send_point(4'd15, 32'd0, 8'd255);
      send_point(4'd15, 32'd123, 8'd0);
      send_point(4'd7, 32'hFFFF_FFFF, 8'd1);
      drain();

      write_counts(6'd2, 6'd4);
      send_load(4'd0, 5'd0, 5'd0, 8'd255);
      send_load(4'd0, 5'd0, 5'd1, 8'd255);
      send_load(4'd0, 5'd1, 5'd0, 8'd0);
      send_load(4'd0, 5'd1, 5'd1, 8'd1);
      send_load(4'd0, 5'd2, 5'd0, 8'd128);
      send_load(4'd0, 5'd2, 5'd1, 8'd7);
      send_load(4'd0, 5'd3, 5'd0, 8'd254);
      send_load(4'd0, 5'd3, 5'd1, 8'd3);
      send_point(4'd0, 32'd15, 8'd2);
      send_point(4'd0, 32'd16, 8'd2);
      send_point(4'd0, 32'hFFFF_FFFF, 8'd2);
      send_point(4'd0, 32'd4228250624, 8'd255);
      send_point(4'd0, 32'd4228250625, 8'd255);
      send_point(4'd0, 32'd1, 8'd2);
      send_point(4'd0, 32'd80, 8'd3);
      send_point(4'd0, 32'd200, 8'd3);
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) begin
            rows_set[4] = 6'($urandom_range(1, 4));
            cols_set[4] = 6'($urandom_range(1, 12));
         end
         if (p == 1 || p == 2) begin
            snd_idle_pct = 64;
            rcv_idle_pct = 27;
         end else if (p >= 3) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         write_counts(rows_set[p], cols_set[p]);
         // stall the result side while requests keep coming
         if (p == 4) hold_start <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == PHASE_ITEMS / 2) begin
               req_tvalid <= 1'b0;
               while (sb.pending_digits.size() != 0) @(posedge clock);
            end
            random_item((p % 2 == 0) ? 4'd0 : 4'd9);
         end
         drain();
      end

      $display("covered %0d matrix loads and %0d points, %0d digits checked (%0d overflow)",
               sb.n_loads, sb.n_points, sb.n_digits, sb.n_overflows);
      $display("count settings from 0 to 63 under three idle patterns, %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_digits.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/dnpd_pkg.sv
rtl/dnpd_cell.sv
rtl/dnpd_divider.sv
rtl/digital_net_point_digits.sv
test/tb_digital_net_point_digits.sv
